### rtl/binary_lifting_lca_query_macros.svh
// assertion macros for the lca query block
// used by the top level; needs no other file
`ifndef BINARY_LIFTING_LCA_QUERY_MACROS_SVH
`define BINARY_LIFTING_LCA_QUERY_MACROS_SVH

`ifndef NO_ASSERTIONS
// property that must hold at every edge out of reset
`define BLCA_ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// same-cycle implication
`define BLCA_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define BLCA_ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define BLCA_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`endif

`endif

### rtl/blca_pkg.sv
// shared types, widths and codes of the lca query block
// no dependencies
package blca_pkg;

  // sizes
  localparam int NODE_W  = 10;
  localparam int NODES   = 1 << NODE_W;
  localparam int DEPTH_W = 10;
  localparam int DIST_W  = 11;
  localparam int LEVELS  = 10;
  localparam int LVL_W   = $clog2(LEVELS);
  localparam int JT_AW   = NODE_W + LVL_W;
  localparam int JT_DEPTH = 1 << JT_AW;
  localparam int OP_W    = 2;

  // stream packing
  localparam int IN_TDATA_W  = ((2 * NODE_W + DEPTH_W + 7) / 8) * 8;
  localparam int IN_PAD_W    = IN_TDATA_W - 2 * NODE_W - DEPTH_W;
  localparam int OUT_TDATA_W = ((NODE_W + DIST_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - NODE_W - DIST_W;

  localparam logic [LVL_W-1:0] LVL_ZERO   = '0;
  localparam logic [LVL_W-1:0] LVL_TOP    = LVL_W'(LEVELS - 1);
  localparam logic [LVL_W-1:0] LVL_BLD_END = LVL_W'(LEVELS - 2);

  // command codes
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic              borrow;
    logic              zero;
    logic [DIST_W-1:0] value;
  } alu_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_Q_DB,
    ST_Q_SWAP,
    ST_Q_NEG,
    ST_Q_LIFT,
    ST_Q_LWAIT,
    ST_Q_EQ,
    ST_Q_CLIMB,
    ST_Q_ANC,
    ST_Q_DANC,
    ST_Q_SUM,
    ST_Q_OUT,
    ST_B_INIT,
    ST_B_RD1,
    ST_B_RD2,
    ST_B_WR
  } blca_state_t;

endpackage

### rtl/blca_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module blca_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/blca_alu.sv
// shared add / subtract / compare unit of the lca query block
// depends on blca_pkg
module blca_alu import blca_pkg::*; (
  input  alu_op_t           op,
  input  logic [DIST_W-1:0] a,
  input  logic [DIST_W-1:0] b,
  output alu_res_t          res
);

  logic            sub;
  logic [DIST_W:0] wide;

  // one adder: subtract as a plus inverted b plus one
  always_comb begin
    sub        = (op == ALU_SUB);
    wide       = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{DIST_W{1'b0}}, sub};
    res.value  = wide[DIST_W-1:0];
    res.zero   = (wide[DIST_W-1:0] == '0);
    res.borrow = sub & ~wide[DIST_W];
  end

endmodule

### rtl/binary_lifting_lca_query.sv
// top level of the lca query block: sequencer, jump table and depth memories
// depends on blca_pkg, blca_ram, blca_alu and binary_lifting_lca_query_macros.svh
//
//   channel  dir  handshake             payload
//   s_*      in   s_tvalid / s_tready   tuser: op; tdata: node_a, node_b, depth
//   m_*      out  m_tvalid / m_tready   tdata: ancestor, distance
//   cfg_*    in   cfg_valid / cfg_ready cfg_data: node_count
//
// load writes a node's parent and depth; build fills jump table levels 1 to
// LEVELS - 1 for nodes 1 to node_count, with two reads and one write per entry.
// a query is paced by the two jump table read ports and the one shared adder.
// s_tready is high only while the sequencer is idle; a finished result sits in
// the output register so the next transaction can start while it waits.
// rst clears control state and sets node_count to 1; memories are not cleared.
`include "binary_lifting_lca_query_macros.svh"

module binary_lifting_lca_query import blca_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [OP_W-1:0]        s_tuser,   // op
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // node_a, node_b, depth, zero pad
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // ancestor, distance, zero pad
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [NODE_W-1:0]      cfg_data
);

  blca_state_t state, state_next;

  logic [NODE_W-1:0]  node_count;
  logic [NODE_W-1:0]  a_reg, b_reg, x, y, anc, i_cnt;
  logic [DEPTH_W-1:0] da, db, diff, danc;
  logic [DIST_W-1:0]  sum;
  logic [LVL_W-1:0]   lvl, lvl_dn;

  logic               s_acc;
  logic [NODE_W-1:0]  in_a, in_b;
  logic [DEPTH_W-1:0] in_d;
  logic               out_free;

  logic               jt_we;
  logic [JT_AW-1:0]   jt_waddr, jt_raddr_a, jt_raddr_b;
  logic [NODE_W-1:0]  jt_wdata, jq_a, jq_b;
  logic               dp_we;
  logic [NODE_W-1:0]  dp_raddr;
  logic [DEPTH_W-1:0] dq;

  alu_op_t            alu_op;
  logic [DIST_W-1:0]  alu_a, alu_b;
  alu_res_t           alu_res;

  logic [NODE_W-1:0]  x_new, y_new;

  // input unpacking and handshakes
  assign in_a      = s_tdata[NODE_W-1:0];
  assign in_b      = s_tdata[2*NODE_W-1:NODE_W];
  assign in_d      = s_tdata[2*NODE_W+DEPTH_W-1:2*NODE_W];
  assign s_tready  = (state == ST_IDLE);
  assign s_acc     = s_tvalid & s_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = ~m_tvalid | m_tready;

  // climb step: move both nodes up unless their ancestors meet
  assign x_new  = alu_res.zero ? x : jq_a;
  assign y_new  = alu_res.zero ? y : jq_b;
  assign lvl_dn = (lvl == LVL_ZERO) ? LVL_ZERO : lvl - 1'b1;

  // jump table, two copies with shared writes for two reads a cycle
  blca_ram #(.WIDTH(NODE_W), .DEPTH(JT_DEPTH)) u_jt_a (
    .clk   (clk),
    .we    (jt_we),
    .waddr (jt_waddr),
    .wdata (jt_wdata),
    .raddr (jt_raddr_a),
    .rdata (jq_a)
  );

  blca_ram #(.WIDTH(NODE_W), .DEPTH(JT_DEPTH)) u_jt_b (
    .clk   (clk),
    .we    (jt_we),
    .waddr (jt_waddr),
    .wdata (jt_wdata),
    .raddr (jt_raddr_b),
    .rdata (jq_b)
  );

  // node depth memory
  blca_ram #(.WIDTH(DEPTH_W), .DEPTH(NODES)) u_depth (
    .clk   (clk),
    .we    (dp_we),
    .waddr (in_a),
    .wdata (in_d),
    .raddr (dp_raddr),
    .rdata (dq)
  );

  // shared adder / comparator
  blca_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_acc) begin
          case (s_tuser)
            OP_QUERY: state_next = ST_Q_DB;
            OP_BUILD: state_next = ST_B_INIT;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_Q_DB:    state_next = ST_Q_SWAP;
      ST_Q_SWAP:  state_next = (!alu_res.borrow && !alu_res.zero) ? ST_Q_LIFT : ST_Q_NEG;
      ST_Q_NEG:   state_next = ST_Q_LIFT;
      ST_Q_LIFT: begin
        if (diff[lvl]) begin
          state_next = ST_Q_LWAIT;
        end else if (lvl == LVL_TOP) begin
          state_next = ST_Q_EQ;
        end
      end
      ST_Q_LWAIT: state_next = (lvl == LVL_TOP) ? ST_Q_EQ : ST_Q_LIFT;
      ST_Q_EQ:    state_next = alu_res.zero ? ST_Q_DANC : ST_Q_CLIMB;
      ST_Q_CLIMB: state_next = (lvl == LVL_ZERO) ? ST_Q_ANC : ST_Q_CLIMB;
      ST_Q_ANC:   state_next = ST_Q_DANC;
      ST_Q_DANC:  state_next = ST_Q_SUM;
      ST_Q_SUM:   state_next = ST_Q_OUT;
      ST_Q_OUT:   state_next = out_free ? ST_IDLE : ST_Q_OUT;
      ST_B_INIT:  state_next = (alu_res.zero || LEVELS < 2) ? ST_IDLE : ST_B_RD1;
      ST_B_RD1:   state_next = ST_B_RD2;
      ST_B_RD2:   state_next = ST_B_WR;
      ST_B_WR:    state_next = (alu_res.zero && lvl == LVL_BLD_END) ? ST_IDLE : ST_B_RD1;
      default:    state_next = ST_IDLE;
    endcase
  end

  // memory ports and adder operands
  always_comb begin
    jt_we      = 1'b0;
    jt_waddr   = {in_a, LVL_ZERO};
    jt_wdata   = in_b;
    jt_raddr_a = {x, lvl};
    jt_raddr_b = {y, lvl};
    dp_we      = 1'b0;
    dp_raddr   = a_reg;
    alu_op     = ALU_SUB;
    alu_a      = '0;
    alu_b      = '0;
    case (state)
      ST_IDLE: begin
        dp_raddr = in_a;
        if (s_acc && s_tuser == OP_LOAD) begin
          jt_we = 1'b1;
          dp_we = 1'b1;
        end
      end
      ST_Q_DB: dp_raddr = b_reg;
      ST_Q_SWAP: begin
        alu_a = DIST_W'(da);
        alu_b = DIST_W'(dq);
      end
      ST_Q_NEG: begin
        alu_a = DIST_W'(db);
        alu_b = DIST_W'(da);
      end
      ST_Q_LIFT: jt_raddr_a = {y, lvl};
      ST_Q_EQ: begin
        alu_a      = DIST_W'(x);
        alu_b      = DIST_W'(y);
        jt_raddr_a = {x, LVL_TOP};
        jt_raddr_b = {y, LVL_TOP};
      end
      ST_Q_CLIMB: begin
        alu_a      = DIST_W'(jq_a);
        alu_b      = DIST_W'(jq_b);
        jt_raddr_a = {x_new, lvl_dn};
        jt_raddr_b = {y_new, lvl_dn};
      end
      ST_Q_DANC: dp_raddr = anc;
      ST_Q_SUM: begin
        alu_op = ALU_ADD;
        alu_a  = DIST_W'(da);
        alu_b  = DIST_W'(db);
      end
      ST_Q_OUT: begin
        alu_a = sum;
        alu_b = {danc, 1'b0};
      end
      ST_B_INIT: begin
        alu_a = DIST_W'(node_count);
      end
      ST_B_RD1: jt_raddr_a = {i_cnt, lvl};
      ST_B_RD2: jt_raddr_a = {jq_a, lvl};
      ST_B_WR: begin
        jt_we    = 1'b1;
        jt_waddr = {i_cnt, lvl + 1'b1};
        jt_wdata = jq_a;
        alu_a    = DIST_W'(i_cnt);
        alu_b    = DIST_W'(node_count);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      lvl        <= LVL_ZERO;
      m_tvalid   <= 1'b0;
      node_count <= NODE_W'(1);
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        node_count <= cfg_data;
      end
      if (state == ST_Q_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_Q_SWAP: lvl <= LVL_ZERO;
        ST_Q_LIFT: begin
          if (!diff[lvl] && lvl != LVL_TOP) begin
            lvl <= lvl + 1'b1;
          end
        end
        ST_Q_LWAIT: begin
          if (lvl != LVL_TOP) begin
            lvl <= lvl + 1'b1;
          end
        end
        ST_Q_EQ:    lvl <= LVL_TOP;
        ST_Q_CLIMB: lvl <= lvl_dn;
        ST_B_INIT:  lvl <= LVL_ZERO;
        ST_B_WR: begin
          if (alu_res.zero && lvl != LVL_BLD_END) begin
            lvl <= lvl + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_acc) begin
          a_reg <= in_a;
          b_reg <= in_b;
        end
      end
      ST_Q_DB: da <= dq;
      ST_Q_SWAP: begin
        db <= dq;
        if (!alu_res.borrow && !alu_res.zero) begin
          x    <= b_reg;
          y    <= a_reg;
          diff <= alu_res.value[DEPTH_W-1:0];
        end else begin
          x <= a_reg;
          y <= b_reg;
        end
      end
      ST_Q_NEG:   diff <= alu_res.value[DEPTH_W-1:0];
      ST_Q_LWAIT: y <= jq_a;
      ST_Q_EQ:    anc <= x;
      ST_Q_CLIMB: begin
        x <= x_new;
        y <= y_new;
      end
      ST_Q_ANC: anc <= jq_a;
      ST_Q_SUM: begin
        sum  <= alu_res.value;
        danc <= dq;
      end
      ST_Q_OUT: begin
        if (out_free) begin
          m_tdata <= {{OUT_PAD_W{1'b0}}, alu_res.value, anc};
        end
      end
      ST_B_INIT: i_cnt <= NODE_W'(1);
      ST_B_WR: begin
        if (alu_res.zero) begin
          i_cnt <= NODE_W'(1);
        end else begin
          i_cnt <= i_cnt + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // checks
  `BLCA_ASSERT_IMPL(a_jt_we, clk, rst, jt_we, state == ST_IDLE || state == ST_B_WR, "bad jt write")
  `BLCA_ASSERT_ALWAYS(a_lvl_range, clk, rst, (lvl <= LVL_TOP), "level counter out of range")
  `BLCA_ASSERT_IMPL(a_res_src, clk, rst, $rose(m_tvalid), $past(state) == ST_Q_OUT, "stray result")

endmodule

### verif/testbench.sv
// self-checking testbench for binary_lifting_lca_query: tree loads, jump table builds and
// lca queries checked against an internal predictor; depends on blca_pkg and the rtl only
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import blca_pkg::*;

  // op code with no meaning, the block drops it
  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

  // tracks the block's tables and the answers still owed
  class lca_scoreboard;
    typedef struct packed {
      logic [NODE_W-1:0] ancestor;
      logic [DIST_W-1:0] distance;
    } lca_answer_t;

    logic [NODE_W-1:0]  ancestor_rows [NODES][LEVELS];
    logic [DEPTH_W-1:0] node_depth [NODES];
    logic [NODE_W-1:0]  node_count;
    lca_answer_t        answers_due [$];
    int                 mismatches;

    function new();
      node_count = 1;
      mismatches = 0;
    endfunction

    function void set_count(input logic [NODE_W-1:0] count);
      node_count = count;
    endfunction

    function int pending();
      return answers_due.size();
    endfunction

    // lift the deeper node, then climb both from the top level down
    function lca_answer_t find_lca(input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b);
      lca_answer_t       ans;
      logic [NODE_W-1:0] x, y, tmp, px, py;
      logic [DEPTH_W-1:0] diff;
      int                lvl;
      x = a;
      y = b;
      if (node_depth[x] > node_depth[y]) begin
        tmp = x;
        x = y;
        y = tmp;
      end
      diff = node_depth[y] - node_depth[x];
      for (lvl = 0; lvl < LEVELS; lvl++)
        if (diff[lvl]) y = ancestor_rows[y][lvl];
      if (x == y) begin
        ans.ancestor = x;
      end else begin
        for (lvl = LEVELS - 1; lvl >= 0; lvl--) begin
          px = ancestor_rows[x][lvl];
          py = ancestor_rows[y][lvl];
          if (px != py) begin
            x = px;
            y = py;
          end
        end
        ans.ancestor = ancestor_rows[x][0];
      end
      // wraps when the loaded depths do not fit the parents
      ans.distance = DIST_W'(node_depth[a]) + DIST_W'(node_depth[b])
                     - {node_depth[ans.ancestor], 1'b0};
      return ans;
    endfunction

    // apply one accepted command transaction
    function void note_input(input logic [OP_W-1:0] op, input logic [NODE_W-1:0] a,
                             input logic [NODE_W-1:0] b, input logic [DEPTH_W-1:0] d);
      int lvl, idx;
      case (op)
        OP_LOAD: begin
          ancestor_rows[a][0] = b;
          node_depth[a] = d;
        end
        OP_BUILD: begin
          // a 10-bit count never reaches past the last node
          for (lvl = 1; lvl < LEVELS; lvl++)
            for (idx = 1; idx <= node_count; idx++)
              ancestor_rows[idx][lvl] = ancestor_rows[ancestor_rows[idx][lvl-1]][lvl-1];
        end
        OP_QUERY: answers_due = {answers_due, find_lca(a, b)};
        default: ;
      endcase
    endfunction

    task report(input string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      mismatches++;
    endtask

    // compare one result transaction with the oldest owed answer
    task check_result(input logic [OUT_TDATA_W-1:0] tdata);
      lca_answer_t       want;
      logic [NODE_W-1:0] got_anc;
      logic [DIST_W-1:0] got_dist;
      got_anc  = tdata[NODE_W-1:0];
      got_dist = tdata[NODE_W +: DIST_W];
      if (answers_due.size() == 0) begin
        report($sformatf("unexpected result ancestor %0d distance %0d", got_anc, got_dist));
        return;
      end
      want = answers_due.pop_front();
      if (got_anc !== want.ancestor)
        report($sformatf("ancestor %0d, expected %0d", got_anc, want.ancestor));
      if (got_dist !== want.distance)
        report($sformatf("distance %0d, expected %0d", got_dist, want.distance));
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [OP_W-1:0]        s_tuser = '0;   // op
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // node_a, node_b, depth, zero pad
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // ancestor, distance, zero pad
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [NODE_W-1:0]      cfg_data = '0;

  lca_scoreboard lca_check = new();

  // tree as generated, used to pick related query pairs
  int tree_parent [NODES];
  int tree_depth  [NODES];
  int tree_n = 1;
  bit idle_on = 1'b1;
  int item_total = 0;
  int stall_left = 0;

  binary_lifting_lca_query dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  // result side: check each transaction, stall in random bursts
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) lca_check.check_result(m_tdata);
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 13);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // one command transaction, with an optional gap before it
  task automatic send_item(input logic [OP_W-1:0] op, input int a, input int b, input int d);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= IN_TDATA_W'({DEPTH_W'(d), NODE_W'(b), NODE_W'(a)});
    do @(posedge clk); while (!s_tready);
    lca_check.note_input(op, NODE_W'(a), NODE_W'(b), DEPTH_W'(d));
    if (op != OP_IGNORED) item_total++;
  endtask

  // drain answers, then give a pending build time to finish
  task automatic settle();
    s_tvalid <= 1'b0;
    while (lca_check.pending() != 0) @(posedge clk);
    repeat (64 + 27 * lca_check.node_count) @(posedge clk);
  endtask

  task automatic write_count(input int n);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= NODE_W'(n);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    lca_check.set_count(NODE_W'(n));
  endtask

  // random tree over nodes 1..n; chain_pct sets how deep, skew_pct how many bad depths
  task automatic load_tree(input int n, input int chain_pct, input int skew_pct);
    int order [NODES];
    int k, j, tmp, node, p, d;
    for (k = 0; k < n; k++) order[k] = k + 1;
    for (k = n - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (k = 0; k < n; k++) begin
      node = order[k];
      if (k == 0) begin
        p = node;
        d = 0;
      end else begin
        p = ($urandom_range(0, 99) < chain_pct) ? order[k-1] : order[$urandom_range(0, k-1)];
        d = tree_depth[p] + 1;
      end
      tree_parent[node] = p;
      tree_depth[node]  = d;
      if ($urandom_range(0, 99) < skew_pct) d = $urandom_range(0, 1023);
      send_item(OP_LOAD, node, p, d);
    end
    tree_n = n;
  endtask

  // query pair: same node, node and one of its ancestors, or any two nodes
  task automatic pick_pair(output int a, output int b);
    int tmp;
    b = $urandom_range(1, tree_n);
    case ($urandom_range(0, 7))
      0: a = b;
      1, 2: begin
        a = b;
        repeat ($urandom_range(1, 12)) a = tree_parent[a];
      end
      default: a = $urandom_range(1, tree_n);
    endcase
    if ($urandom_range(0, 1)) begin
      tmp = a;
      a = b;
      b = tmp;
    end
  endtask

  // mostly queries, with dropped ops, reloads, stray loads and rebuilds mixed in
  task automatic run_queries(input int count);
    int r, a, b, p;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_item(OP_IGNORED, $urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 1023));
      end else if (r < 16 && tree_n < 1023) begin
        // nodes outside the tree are never read back
        send_item(OP_LOAD, $urandom_range(tree_n + 1, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 1023));
      end else if (r < 26) begin
        // parent stays inside the tree so every later read hits a written entry
        a = $urandom_range(1, tree_n);
        p = $urandom_range(1, tree_n);
        tree_parent[a] = p;
        send_item(OP_LOAD, a, p, $urandom_range(0, 1) ? tree_depth[p] + 1
                                                       : $urandom_range(0, 1023));
      end else if (r < 30 && lca_check.node_count <= 64) begin
        send_item(OP_BUILD, 0, 0, 0);
      end else begin
        pick_pair(a, b);
        send_item(OP_QUERY, a, b, $urandom_range(0, 1023));
      end
    end
  endtask

  // stimulus
  initial begin
    int hand_parent [8];
    int hand_depth  [8];
    int k, n;
    hand_parent = '{0, 1, 1, 1, 2, 4, 5, 3};
    hand_depth  = '{0, 0, 1, 1, 2, 3, 4, 2};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: dropped op, single-node tree at the reset count
    send_item(OP_IGNORED, 1023, 1023, 1023);
    send_item(OP_LOAD, 1, 1, 0);
    send_item(OP_BUILD, 0, 0, 0);
    send_item(OP_QUERY, 1, 1, 0);

    // directed: seven-node tree, related and unrelated pairs
    write_count(7);
    for (k = 1; k < 8; k++) send_item(OP_LOAD, k, hand_parent[k], hand_depth[k]);
    send_item(OP_BUILD, 0, 0, 0);
    send_item(OP_QUERY, 5, 7, 0);
    send_item(OP_QUERY, 6, 1, 0);
    send_item(OP_QUERY, 7, 7, 0);
    send_item(OP_QUERY, 6, 3, 0);
    send_item(OP_QUERY, 4, 5, 0);

    // directed: depth far from the parent's and full-width difference
    send_item(OP_LOAD, 7, 3, 1023);
    send_item(OP_QUERY, 7, 1, 0);
    send_item(OP_QUERY, 4, 7, 0);

    // directed: zero count makes build a no-op
    write_count(0);
    send_item(OP_BUILD, 0, 0, 0);
    send_item(OP_QUERY, 6, 7, 0);

    // full-size tree
    write_count(1023);
    load_tree(1023, 50, 0);
    send_item(OP_BUILD, 0, 0, 0);
    run_queries(40);
    write_count(0);
    send_item(OP_BUILD, 0, 0, 0);
    run_queries(15);

    // smallest tree written explicitly
    write_count(1);
    load_tree(1, 0, 0);
    send_item(OP_BUILD, 0, 0, 0);
    run_queries(8);

    // small random trees, some with inconsistent depths
    while (item_total < 1350) begin
      if (item_total > 1250) idle_on = 1'b0;
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(25, 120) : $urandom_range(2, 24);
      write_count(n);
      load_tree(n, $urandom_range(0, 100), ($urandom_range(0, 3) == 0) ? 15 : 0);
      send_item(OP_BUILD, 0, 0, 0);
      run_queries($urandom_range(10, 30));
    end

    // drain
    s_tvalid <= 1'b0;
    while (lca_check.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (lca_check.mismatches == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
